FILE: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define LBCS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, skipped while reset is high.
`define LBCS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define LBCS_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication through reset");

`endif

FILE: rtl/core/lbcs_pkg.sv
// Types, constants and helper functions of the long bracket comment scanner.
`default_nettype none
package lbcs_pkg;

   localparam int unsigned CH_W      = 21;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned LVL_W     = 8;
   localparam int unsigned KW_W      = 3;
   localparam int unsigned REQ_DW    = 24;
   localparam int unsigned REQ_UW    = 2;
   localparam int unsigned RSP_DW    = 40;
   localparam int unsigned Q_DEPTH   = 4;
   localparam int unsigned Q_PTR_W   = 2;
   localparam int unsigned Q_CNT_W   = 3;

   localparam logic [LEN_W-1:0] LEN_CAP   = 16'hFFFF;
   localparam logic [LVL_W-1:0] MAX_LEVEL = 8'd255;
   localparam logic [KW_W-1:0]  KW_LEN    = 3'd5;

   // ASCII code points of interest
   localparam logic [CH_W-1:0] CH_TAB    = 21'd9;
   localparam logic [CH_W-1:0] CH_NL     = 21'd10;
   localparam logic [CH_W-1:0] CH_CR     = 21'd13;
   localparam logic [CH_W-1:0] CH_SPACE  = 21'd32;
   localparam logic [CH_W-1:0] CH_DASH   = 21'd45;
   localparam logic [CH_W-1:0] CH_EQ     = 21'd61;
   localparam logic [CH_W-1:0] CH_LBRACK = 21'd91;
   localparam logic [CH_W-1:0] CH_RBRACK = 21'd93;
   localparam logic [CH_W-1:0] CH_UNDER  = 21'd95;
   localparam logic [CH_W-1:0] CH_C      = 21'd99;
   localparam logic [CH_W-1:0] CH_N      = 21'd110;
   localparam logic [CH_W-1:0] CH_O      = 21'd111;
   localparam logic [CH_W-1:0] CH_S      = 21'd115;
   localparam logic [CH_W-1:0] CH_T      = 21'd116;

   // token kinds as reported
   localparam logic [1:0] KIND_COMMENT = 2'd0;
   localparam logic [1:0] KIND_STRING  = 2'd1;
   localparam logic [1:0] KIND_CONST   = 2'd2;

   // allow bit positions
   localparam int unsigned AL_COMMENT = 0;
   localparam int unsigned AL_STRING  = 1;
   localparam int unsigned AL_CONST   = 2;

   typedef enum logic [3:0] {
      CC_OTHER,
      CC_WS,
      CC_NL,
      CC_IDENT,
      CC_DASH,
      CC_LBRACK,
      CC_RBRACK,
      CC_EQ,
      CC_EOF,
      CC_C,
      CC_O,
      CC_N,
      CC_S,
      CC_T
   } char_class_type;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_WS,
      PH_DASH1,
      PH_DASH2,
      PH_LINE,
      PH_OPEN_EQ,
      PH_BODY,
      PH_CLOSE_EQ,
      PH_KW,
      PH_KW_AFTER,
      PH_KW_WS
   } phase_type;

   // one classified beat as it travels through the queue
   typedef struct packed {
      logic           first;
      logic [2:0]     allow;
      char_class_type cls;
   } lbcs_item_type;

   // expected class of keyword letter at a position of "const"
   function automatic char_class_type kw_expect(input logic [KW_W-1:0] idx);
      char_class_type r;
      case (idx)
         3'd0:    r = CC_C;
         3'd1:    r = CC_O;
         3'd2:    r = CC_N;
         3'd3:    r = CC_S;
         3'd4:    r = CC_T;
         default: r = CC_OTHER;
      endcase
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] inc_len(input logic [LEN_W-1:0] v);
      return (v < LEN_CAP) ? LEN_W'(v + 1'b1) : LEN_CAP;
   endfunction

   function automatic logic [LVL_W-1:0] inc_lvl(input logic [LVL_W-1:0] v);
      return (v < MAX_LEVEL) ? LVL_W'(v + 1'b1) : MAX_LEVEL;
   endfunction

   function automatic logic is_ws_cls(input char_class_type c);
      return (c == CC_WS) || (c == CC_NL);
   endfunction

   function automatic logic is_ident_cls(input char_class_type c);
      return (c == CC_IDENT) || (c == CC_C) || (c == CC_O) || (c == CC_N) ||
             (c == CC_S) || (c == CC_T);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/long_bracket_comment_scanner.sv
// Top level of the long bracket comment scanner.
`default_nettype none
// Recognizes one token per scan from a stream of code points: a line or leveled
// block comment, a leveled long string, or the contextual keyword const. A beat
// with first set starts a scan and samples the allow bits; leading ASCII
// whitespace is counted. Each scan ends with one result beat (accept flag,
// kind, skip count, token length; all zero on reject), taken from the beat that
// decides it after the queue; a new first beat drops a running scan with no
// result. Throughput is one beat per cycle: the front end classifies each code
// point into a four-entry queue, and the back end state machine takes one queue
// entry per cycle whenever its result register is empty or being drained.
module long_bracket_comment_scanner (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // allow_comment, allow_long_string, allow_const, ch[20:0]
   input  wire logic [lbcs_pkg::REQ_DW-1:0] req_tdata,
   // first, at_end
   input  wire logic [lbcs_pkg::REQ_UW-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // accepted, token_kind[1:0], skipped[15:0], token_length[15:0], zero pad
   output logic [lbcs_pkg::RSP_DW-1:0]      rsp_tdata
);
   import lbcs_pkg::*;

   lbcs_item_type push_item, head_item;
   logic          q_ready, q_push, q_valid, q_pop;

   lbcs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   lbcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .not_full  (q_ready),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_item (head_item)
   );

   lbcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

FILE: rtl/core/lbcs_front.sv
// Front end: takes request beats and reduces each code point to a character class.
`default_nettype none
module lbcs_front (
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [lbcs_pkg::REQ_DW-1:0] req_tdata,
   input  wire logic [lbcs_pkg::REQ_UW-1:0] req_tuser,
   input  wire logic                        q_ready,
   output logic                             q_push,
   output lbcs_pkg::lbcs_item_type          q_item
);
   import lbcs_pkg::*;

   logic [CH_W-1:0] ch;
   logic            at_end;
   char_class_type  cls;

   assign ch     = req_tdata[REQ_DW-1:3];
   assign at_end = req_tuser[1];

   // character classification, end of file overrides the code point
   always_comb begin
      if (at_end) begin
         cls = CC_EOF;
      end else if (ch == CH_NL) begin
         cls = CC_NL;
      end else if ((ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE) begin
         cls = CC_WS;
      end else if (ch == CH_DASH) begin
         cls = CC_DASH;
      end else if (ch == CH_LBRACK) begin
         cls = CC_LBRACK;
      end else if (ch == CH_RBRACK) begin
         cls = CC_RBRACK;
      end else if (ch == CH_EQ) begin
         cls = CC_EQ;
      end else if (ch == CH_C) begin
         cls = CC_C;
      end else if (ch == CH_O) begin
         cls = CC_O;
      end else if (ch == CH_N) begin
         cls = CC_N;
      end else if (ch == CH_S) begin
         cls = CC_S;
      end else if (ch == CH_T) begin
         cls = CC_T;
      end else if ((ch >= 21'd97 && ch <= 21'd122) || (ch >= 21'd65 && ch <= 21'd90) ||
                   (ch >= 21'd48 && ch <= 21'd57) || ch == CH_UNDER) begin
         cls = CC_IDENT;
      end else begin
         cls = CC_OTHER;
      end
   end

   assign q_item.first = req_tuser[0];
   assign q_item.allow = req_tdata[2:0];
   assign q_item.cls   = cls;
   assign q_push       = req_tvalid & q_ready;
   assign req_tready   = q_ready;

endmodule
`default_nettype wire

FILE: rtl/core/lbcs_queue.sv
// Small FIFO of classified beats between front end and back end.
`default_nettype none
module lbcs_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire lbcs_pkg::lbcs_item_type push_item,
   output logic                         not_full,
   input  wire logic                    pop,
   output logic                         not_empty,
   output lbcs_pkg::lbcs_item_type      head_item
);
   import lbcs_pkg::*;

   lbcs_item_type        slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign not_full  = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push & not_full;
   assign do_pop    = pop & not_empty;
   assign head_item = slot_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = Q_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = Q_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/lbcs_back.sv
// Back end: token state machine over classified beats, with the result register.
`default_nettype none
module lbcs_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  wire lbcs_pkg::lbcs_item_type     q_item,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [lbcs_pkg::RSP_DW-1:0]      rsp_tdata
);
   import lbcs_pkg::*;

   phase_type          phase_ff, phase_in, cur_phase;
   logic [2:0]         allowed_ff, allowed_in;
   logic [LVL_W-1:0]   open_ff, open_in;
   logic [LVL_W-1:0]   close_ff, close_in;
   logic [KW_W-1:0]    kw_ff, kw_in;
   logic [LEN_W-1:0]   skip_ff, skip_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [1:0]         bk_ff, bk_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0]  rsp_data_ff, rsp_data_in;

   logic               step;
   logic               emit, emit_ok;
   logic [1:0]         emit_kind;
   logic               do_line, do_body;
   char_class_type     cls;

   assign cls   = q_item.cls;
   assign step  = q_valid & (~rsp_valid_ff | rsp_tready);
   assign q_pop = step;

   // next state and result for one beat
   always_comb begin
      phase_in   = phase_ff;
      allowed_in = allowed_ff;
      open_in    = open_ff;
      close_in   = close_ff;
      kw_in      = kw_ff;
      skip_in    = skip_ff;
      len_in     = len_ff;
      bk_in      = bk_ff;
      emit       = 1'b0;
      emit_ok    = 1'b0;
      emit_kind  = KIND_COMMENT;
      do_line    = 1'b0;
      do_body    = 1'b0;
      cur_phase  = phase_ff;

      if (step) begin
         // a first beat restarts the scan
         if (q_item.first) begin
            allowed_in = q_item.allow;
            open_in    = '0;
            close_in   = '0;
            kw_in      = '0;
            skip_in    = '0;
            len_in     = '0;
            bk_in      = KIND_COMMENT;
            if (q_item.allow == 3'b000) begin
               cur_phase = PH_IDLE;
               emit      = 1'b1;
            end else begin
               cur_phase = PH_WS;
            end
         end
         phase_in = cur_phase;

         unique case (cur_phase)
            PH_IDLE: begin
            end
            PH_WS: begin
               if (is_ws_cls(cls)) begin
                  skip_in = inc_len(skip_in);
               end else if (allowed_in[AL_COMMENT] && cls == CC_DASH) begin
                  len_in   = inc_len(len_in);
                  phase_in = PH_DASH1;
               end else if (allowed_in[AL_STRING] && cls == CC_LBRACK) begin
                  len_in   = inc_len(len_in);
                  bk_in    = KIND_STRING;
                  open_in  = '0;
                  phase_in = PH_OPEN_EQ;
               end else if (allowed_in[AL_CONST] && cls == CC_C) begin
                  len_in   = inc_len(len_in);
                  kw_in    = 3'd1;
                  phase_in = PH_KW;
               end else begin
                  emit = 1'b1;
               end
            end
            PH_DASH1: begin
               if (cls != CC_DASH) begin
                  emit = 1'b1;
               end else begin
                  len_in   = inc_len(len_in);
                  phase_in = PH_DASH2;
               end
            end
            PH_DASH2: begin
               if (cls == CC_LBRACK) begin
                  len_in   = inc_len(len_in);
                  bk_in    = KIND_COMMENT;
                  open_in  = '0;
                  phase_in = PH_OPEN_EQ;
               end else begin
                  do_line = 1'b1;
               end
            end
            PH_LINE: begin
               do_line = 1'b1;
            end
            PH_OPEN_EQ: begin
               if (cls == CC_EQ) begin
                  open_in = inc_lvl(open_in);
                  len_in  = inc_len(len_in);
               end else if (cls == CC_LBRACK) begin
                  len_in   = inc_len(len_in);
                  phase_in = PH_BODY;
               end else if (bk_in == KIND_COMMENT) begin
                  do_line = 1'b1;
               end else begin
                  emit = 1'b1;
               end
            end
            PH_BODY: begin
               do_body = 1'b1;
            end
            PH_CLOSE_EQ: begin
               if (cls == CC_EQ) begin
                  close_in = inc_lvl(close_in);
                  len_in   = inc_len(len_in);
               end else if (cls == CC_RBRACK && close_in == open_in) begin
                  len_in    = inc_len(len_in);
                  emit      = 1'b1;
                  emit_ok   = 1'b1;
                  emit_kind = bk_in;
               end else begin
                  do_body = 1'b1;
               end
            end
            PH_KW: begin
               if (kw_in >= KW_LEN || cls != kw_expect(kw_in)) begin
                  emit = 1'b1;
               end else begin
                  len_in = inc_len(len_in);
                  kw_in  = KW_W'(kw_in + 1'b1);
                  if (kw_in >= KW_LEN) begin
                     phase_in = PH_KW_AFTER;
                  end
               end
            end
            PH_KW_AFTER: begin
               // whitespace must separate the keyword from what follows
               if (is_ws_cls(cls)) begin
                  phase_in = PH_KW_WS;
               end else begin
                  emit = 1'b1;
               end
            end
            PH_KW_WS: begin
               if (is_ident_cls(cls)) begin
                  emit      = 1'b1;
                  emit_ok   = 1'b1;
                  emit_kind = KIND_CONST;
               end else if (!is_ws_cls(cls)) begin
                  emit = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // line comment body, also entered from the dash and open states
         if (do_line) begin
            if (cls == CC_EOF || cls == CC_NL) begin
               emit      = 1'b1;
               emit_ok   = 1'b1;
               emit_kind = KIND_COMMENT;
            end else begin
               len_in   = inc_len(len_in);
               phase_in = PH_LINE;
            end
         end

         // long bracket body, also re-entered from a failed close
         if (do_body) begin
            if (cls == CC_EOF) begin
               emit      = 1'b1;
               emit_ok   = 1'b1;
               emit_kind = bk_in;
            end else begin
               len_in = inc_len(len_in);
               if (cls == CC_RBRACK) begin
                  close_in = '0;
                  phase_in = PH_CLOSE_EQ;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end

         if (emit) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_ok ? {5'b00000, len_in, skip_in, emit_kind, 1'b1} : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         allowed_ff   <= '0;
         open_ff      <= '0;
         close_ff     <= '0;
         kw_ff        <= '0;
         skip_ff      <= '0;
         len_ff       <= '0;
         bk_ff        <= KIND_COMMENT;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         allowed_ff   <= allowed_in;
         open_ff      <= open_in;
         close_ff     <= close_in;
         kw_ff        <= kw_in;
         skip_ff      <= skip_in;
         len_ff       <= len_in;
         bk_ff        <= bk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/lbcs_checker.sv
// Port-level checks of the scanner, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module lbcs_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [lbcs_pkg::RSP_DW-1:0] rsp_tdata
);
   import lbcs_pkg::*;

   logic             rsp_stall;
   logic             rsp_ok;
   logic [1:0]       rsp_kind;
   logic [LEN_W-1:0] rsp_len;
   logic             rsp_const;

   // result beat fields
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_ok    = rsp_tdata[0];
   assign rsp_kind  = rsp_tdata[2:1];
   assign rsp_len   = rsp_tdata[34:19];
   assign rsp_const = rsp_tvalid && rsp_ok && (rsp_kind == KIND_CONST);

   // a stalled result beat holds
   `LBCS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // a reject carries no kind, skip count or length
   `LBCS_ASSERT_IMP(a_reject_zero, clock, reset, rsp_tvalid && !rsp_ok, rsp_tdata[RSP_DW-1:1] == '0)

   // kind code three never appears
   `LBCS_ASSERT_IMP(a_kind_legal, clock, reset, rsp_tvalid, rsp_kind != 2'b11)

   // an accepted keyword is always five characters long
   `LBCS_ASSERT_IMP(a_const_len, clock, reset, rsp_const, rsp_len == 16'd5)

   // reset empties the result register
   `LBCS_ASSERT_NXT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid)

endmodule

bind long_bracket_comment_scanner lbcs_checker u_lbcs_checker (.*);
`default_nettype wire

FILE: dv/lbcs_token_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the long bracket scanner: watches both streams, predicts each token result.
module lbcs_token_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // allow_comment, allow_long_string, allow_const, ch[20:0]
   input  logic [lbcs_pkg::REQ_DW-1:0]      req_tdata,
   // first, at_end
   input  logic [lbcs_pkg::REQ_UW-1:0]      req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // accepted, token_kind[1:0], skipped[15:0], token_length[15:0], zero pad
   input  logic [lbcs_pkg::RSP_DW-1:0]      rsp_tdata,
   output int                               fail_count,
   output int                               pending,
   output int                               results,
   output int                               accepts
);
   import lbcs_pkg::*;

   typedef struct packed {
      logic        ok;
      logic [1:0]  kind;
      logic [15:0] skipped;
      logic [15:0] length;
   } token_result_type;

   token_result_type pending_tokens[$];

   // scanner state as the predictor sees it
   phase_type   scan_phase;
   logic [2:0]  scan_allow;
   logic [7:0]  opener_eqs;
   logic [7:0]  closer_eqs;
   logic [2:0]  kw_pos;
   logic [15:0] blank_count;
   logic [15:0] token_len;
   logic [15:0] kw_len;
   logic [1:0]  bracket_kind;

   initial begin
      fail_count = 0;
      pending    = 0;
      results    = 0;
      accepts    = 0;
   end

   function automatic logic [15:0] bump16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [7:0] bump_level(input logic [7:0] v);
      return (v >= MAX_LEVEL) ? MAX_LEVEL : v + 8'd1;
   endfunction

   function automatic logic is_blank(input logic [20:0] c);
      return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
   endfunction

   function automatic logic is_word_char(input logic [20:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == CH_UNDER;
   endfunction

   // letter of the keyword expected at a position
   function automatic logic [20:0] keyword_letter(input logic [2:0] idx);
      logic [20:0] r;
      case (idx)
         3'd0:    r = CH_C;
         3'd1:    r = CH_O;
         3'd2:    r = CH_N;
         3'd3:    r = CH_S;
         3'd4:    r = CH_T;
         default: r = '1;
      endcase
      return r;
   endfunction

   task automatic clear_scan();
      scan_phase   = PH_IDLE;
      scan_allow   = '0;
      opener_eqs   = '0;
      closer_eqs   = '0;
      kw_pos       = '0;
      blank_count  = '0;
      token_len    = '0;
      kw_len       = '0;
      bracket_kind = KIND_COMMENT;
   endtask

   // queue the result that ends the scan; a reject carries all zeros
   task automatic emit(input logic ok, input logic [1:0] kind, input logic [15:0] len);
      token_result_type r;
      r.ok      = ok;
      r.kind    = ok ? kind : '0;
      r.skipped = ok ? blank_count : '0;
      r.length  = ok ? len : '0;
      pending_tokens.push_back(r);
      scan_phase = PH_IDLE;
   endtask

   // advance the token recognizer by one accepted beat
   task automatic scan_code_point(input logic first, input logic [2:0] allow,
                                  input logic [20:0] code, input logic eof);
      logic [20:0] c;
      logic        again;
      c = eof ? '0 : code;
      if (first) begin
         clear_scan();
         scan_allow = allow;
         if (allow == 3'b000) emit(1'b0, KIND_COMMENT, '0);
         else scan_phase = PH_WS;
      end
      again = (scan_phase != PH_IDLE);
      // some states hand the same character on to the next state
      while (again) begin
         again = 1'b0;
         case (scan_phase)
            PH_WS: begin
               if (is_blank(c)) begin
                  blank_count = bump16(blank_count);
               end else if (scan_allow[AL_COMMENT] && c == CH_DASH) begin
                  token_len  = bump16(token_len);
                  scan_phase = PH_DASH1;
               end else if (scan_allow[AL_STRING] && c == CH_LBRACK) begin
                  token_len    = bump16(token_len);
                  bracket_kind = KIND_STRING;
                  opener_eqs   = '0;
                  scan_phase   = PH_OPEN_EQ;
               end else if (scan_allow[AL_CONST] && c == CH_C) begin
                  token_len  = bump16(token_len);
                  kw_pos     = 3'd1;
                  scan_phase = PH_KW;
               end else begin
                  emit(1'b0, KIND_COMMENT, '0);
               end
            end
            PH_DASH1: begin
               if (c != CH_DASH) begin
                  emit(1'b0, KIND_COMMENT, '0);
               end else begin
                  token_len  = bump16(token_len);
                  scan_phase = PH_DASH2;
               end
            end
            PH_DASH2: begin
               if (c == CH_LBRACK) begin
                  token_len    = bump16(token_len);
                  bracket_kind = KIND_COMMENT;
                  opener_eqs   = '0;
                  scan_phase   = PH_OPEN_EQ;
               end else begin
                  scan_phase = PH_LINE;
                  again      = 1'b1;
               end
            end
            PH_LINE: begin
               if (eof || c == CH_NL) emit(1'b1, KIND_COMMENT, token_len);
               else token_len = bump16(token_len);
            end
            PH_OPEN_EQ: begin
               if (c == CH_EQ) begin
                  opener_eqs = bump_level(opener_eqs);
                  token_len  = bump16(token_len);
               end else if (c == CH_LBRACK) begin
                  token_len  = bump16(token_len);
                  scan_phase = PH_BODY;
               end else if (bracket_kind == KIND_COMMENT) begin
                  // half an opener after "--" falls back to a line comment
                  scan_phase = PH_LINE;
                  again      = 1'b1;
               end else begin
                  emit(1'b0, KIND_COMMENT, '0);
               end
            end
            PH_BODY: begin
               if (eof) begin
                  emit(1'b1, bracket_kind, token_len);
               end else begin
                  token_len = bump16(token_len);
                  if (c == CH_RBRACK) begin
                     closer_eqs = '0;
                     scan_phase = PH_CLOSE_EQ;
                  end
               end
            end
            PH_CLOSE_EQ: begin
               if (c == CH_EQ) begin
                  closer_eqs = bump_level(closer_eqs);
                  token_len  = bump16(token_len);
               end else if (c == CH_RBRACK && closer_eqs == opener_eqs) begin
                  token_len = bump16(token_len);
                  emit(1'b1, bracket_kind, token_len);
               end else begin
                  scan_phase = PH_BODY;
                  again      = 1'b1;
               end
            end
            PH_KW: begin
               if (kw_pos >= KW_LEN || c != keyword_letter(kw_pos)) begin
                  emit(1'b0, KIND_COMMENT, '0);
               end else begin
                  token_len = bump16(token_len);
                  kw_pos    = kw_pos + 3'd1;
                  if (kw_pos >= KW_LEN) scan_phase = PH_KW_AFTER;
               end
            end
            PH_KW_AFTER: begin
               if (is_word_char(c)) begin
                  emit(1'b0, KIND_COMMENT, '0);
               end else begin
                  kw_len     = token_len;
                  scan_phase = PH_KW_WS;
                  again      = 1'b1;
               end
            end
            PH_KW_WS: begin
               if (is_word_char(c)) emit(1'b1, KIND_CONST, kw_len);
               else if (!is_blank(c)) emit(1'b0, KIND_COMMENT, '0);
            end
            default: scan_phase = PH_IDLE;
         endcase
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // compare result beats first, then feed the input beat of the same edge
   always @(posedge clock) begin : watch
      token_result_type want;
      if (reset) begin
         clear_scan();
         pending_tokens.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_tokens.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_tokens.pop_front();
               check_field("accepted", 16'(want.ok), 16'(rsp_tdata[0]));
               check_field("token_kind", 16'(want.kind), 16'(rsp_tdata[2:1]));
               check_field("skipped", want.skipped, rsp_tdata[18:3]);
               check_field("token_length", want.length, rsp_tdata[34:19]);
               check_field("pad", 16'd0, 16'(rsp_tdata[RSP_DW-1:35]));
               results++;
               if (want.ok) accepts++;
            end
         end
         if (req_tvalid && req_tready)
            scan_code_point(req_tuser[0], req_tdata[2:0], req_tdata[23:3], req_tuser[1]);
      end
      pending = pending_tokens.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the long bracket scanner: clock, reset, code point stimulus, verdict.
module tb;
   import lbcs_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_BEATS = 750;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata;
   logic [REQ_UW-1:0] req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;

   int fail_count;
   int pending;
   int results;
   int accepts;
   int send_idle_pct  = 6;
   int rcv_stall_pct  = 62;
   int beats_sent     = 0;
   int directed_beats = 0;
   int cycle_count    = 0;

   // state of the scan being sent
   logic       scan_first = 1'b0;
   logic [2:0] scan_allow = 3'b000;

   long_bracket_comment_scanner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   lbcs_token_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending),
      .results    (results),
      .accepts    (accepts)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due", cycle_count, pending);
         $display("Mismatches found");
         $finish;
      end
   end

   // one input beat, entered and left at a falling edge
   task automatic put(input logic first, input logic [2:0] allow, input logic [20:0] ch,
                      input logic eof);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_DW'($urandom);
         req_tuser  <= REQ_UW'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ch, allow};
      req_tuser  <= {eof, first};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic open_scan(input logic [2:0] allow);
      scan_first = 1'b1;
      scan_allow = allow;
   endtask

   // allow bits only count on the opening beat, so they are random elsewhere
   task automatic send_char(input logic [20:0] c);
      put(scan_first, scan_first ? scan_allow : 3'($urandom), c, 1'b0);
      scan_first = 1'b0;
   endtask

   task automatic send_eof();
      put(scan_first, scan_first ? scan_allow : 3'($urandom),
          21'($urandom_range(0, 1114111)), 1'b1);
      scan_first = 1'b0;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(21'(s[i]));
   endtask

   task automatic send_repeat(input logic [20:0] c, input int n);
      for (int i = 0; i < n; i++) send_char(c);
   endtask

   function automatic logic [20:0] any_blank();
      logic [20:0] r;
      case ($urandom_range(0, 5))
         0:       r = CH_TAB;
         1:       r = CH_NL;
         2:       r = 21'd11;   // vertical tab
         3:       r = 21'd12;   // form feed
         4:       r = CH_CR;
         default: r = CH_SPACE;
      endcase
      return r;
   endfunction

   task automatic send_blanks(input int n);
      for (int i = 0; i < n; i++) send_char(any_blank());
   endtask

   function automatic logic [20:0] word_char();
      logic [20:0] r;
      case ($urandom_range(0, 3))
         0:       r = "a" + 21'($urandom_range(0, 25));
         1:       r = "A" + 21'($urandom_range(0, 25));
         2:       r = "0" + 21'($urandom_range(0, 9));
         default: r = CH_UNDER;
      endcase
      return r;
   endfunction

   // mix of bracket syntax, words and arbitrary code points
   function automatic logic [20:0] body_char();
      logic [20:0] r;
      int          pick;
      pick = $urandom_range(0, 19);
      if (pick < 4)       r = CH_RBRACK;
      else if (pick < 6)  r = CH_EQ;
      else if (pick == 6) r = CH_LBRACK;
      else if (pick == 7) r = CH_NL;
      else if (pick == 8) r = CH_DASH;
      else if (pick < 14) r = word_char();
      else if (pick == 14)
         // syntax characters with high bits set must not match
         r = 21'(($urandom_range(1, 16) << 16) | ($urandom_range(0, 1) ? CH_RBRACK : CH_DASH));
      else r = 21'($urandom_range(0, 1114111));
      return r;
   endfunction

   function automatic logic [20:0] noise_char();
      logic [20:0] r;
      case ($urandom_range(0, 5))
         0:       r = any_blank();
         1:       r = CH_C;
         2:       r = CH_DASH;
         default: r = body_char();
      endcase
      return r;
   endfunction

   task automatic open_long(input int lvl);
      send_char(CH_LBRACK);
      send_repeat(CH_EQ, lvl);
      send_char(CH_LBRACK);
   endtask

   task automatic close_long(input int lvl);
      send_char(CH_RBRACK);
      send_repeat(CH_EQ, lvl);
      send_char(CH_RBRACK);
   endtask

   // bracket body with the odd closer one level too high; past the level cap it does match
   task automatic send_body(input int n, input int lvl);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) close_long(lvl + 1);
         else send_char(body_char());
      end
   endtask

   task automatic send_line(input int n);
      logic [20:0] c;
      for (int i = 0; i < n; i++) begin
         c = body_char();
         send_char((c == CH_NL) ? CH_SPACE : c);
      end
   endtask

   // close properly, run into end of file, or leave it for the next scan to drop
   task automatic finish_long(input int lvl, input int ending);
      if (ending < 16) close_long(lvl);
      else if (ending < 19) send_eof();
   endtask

   task automatic directed_scans();
      open_scan(3'b000); send_char(CH_DASH);
      open_scan(3'b111); send_text("--hi"); send_char(CH_NL);
      open_scan(3'b001); send_text("--"); send_eof();
      open_scan(3'b111); send_text("-x");
      open_scan(3'b011); send_text("--[==[a]=]b]==]");
      open_scan(3'b001); send_text("--[==x"); send_char(CH_NL);
      open_scan(3'b010); send_text("[[x]]");
      open_scan(3'b010); send_text("[=x");
      open_scan(3'b110); send_text("[==[abc"); send_eof();
      open_scan(3'b001); send_text("--[[ab"); send_eof();
      open_scan(3'b100); send_text("const x");
      open_scan(3'b111); send_text("const");
      send_char(CH_TAB); send_char(CH_NL); send_char(CH_UNDER);
      open_scan(3'b100); send_text("constant");
      open_scan(3'b100); send_text("const"); send_eof();
      open_scan(3'b100); send_text("cons"); send_eof();
      open_scan(3'b111); send_text("const(");
      // no-break space is not a blank
      open_scan(3'b111); send_char(21'h00A0); send_text("--");
      open_scan(3'b111); send_char(21'h10002D);
      // a new opening beat drops the running block
      open_scan(3'b011); send_text("--[[abc");
      open_scan(3'b010); send_text("[[]]");
      send_text("--x");
      open_scan(3'b110); send_text("--");
      open_scan(3'b001); send_text("[[");
      open_scan(3'b111); send_eof();
      open_scan(3'b111);
      send_char(CH_SPACE); send_char(CH_TAB); send_char(CH_NL);
      send_char(21'd11); send_char(21'd12); send_char(CH_CR);
      send_text("[["); send_char(21'h10FFFF); send_text("]]");
      // levels beyond the cap all match
      open_scan(3'b010); open_long(300); send_text("x"); close_long(256);
      open_scan(3'b001); send_text("--"); open_long(254); close_long(255); send_eof();
   endtask

   task automatic random_scan();
      logic [2:0] allow;
      int         shape;
      int         lvl;
      int         ending;
      shape  = $urandom_range(0, 9);
      allow  = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 4) != 0) begin
         case (shape)
            0, 1, 2, 3: allow[AL_COMMENT] = 1'b1;
            4, 5:       allow[AL_STRING]  = 1'b1;
            6, 7:       allow[AL_CONST]   = 1'b1;
            default: ;
         endcase
      end
      lvl    = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 260) : $urandom_range(0, 4);
      ending = $urandom_range(0, 19);
      open_scan(allow);
      send_blanks(($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2));
      case (shape)
         0, 1: begin
            send_repeat(CH_DASH, 2);
            if ($urandom_range(0, 3) == 0) begin
               send_char(CH_LBRACK);
               send_repeat(CH_EQ, $urandom_range(0, 3));
            end
            send_line($urandom_range(0, 12));
            if (ending < 3) send_eof();
            else send_char(CH_NL);
         end
         2, 3: begin
            send_repeat(CH_DASH, 2);
            open_long(lvl);
            send_body($urandom_range(0, 12), lvl);
            finish_long(lvl, ending);
         end
         4, 5: begin
            open_long(lvl);
            send_body(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                 : $urandom_range(0, 12), lvl);
            finish_long(lvl, ending);
         end
         6, 7: begin
            if (ending == 18) begin
               send_text("con");
               send_char(noise_char());
            end else begin
               send_text("const");
               if (ending < 14) begin
                  send_blanks($urandom_range(1, 3));
                  send_char(word_char());
               end else if (ending < 16) begin
                  send_char(word_char());
               end else if (ending == 16) begin
                  send_eof();
               end else begin
                  send_blanks($urandom_range(0, 2));
                  send_char(CH_LBRACK);
               end
            end
         end
         8: begin
            for (int i = $urandom_range(1, 8); i > 0; i--) send_char(noise_char());
            if (ending < 5) send_eof();
         end
         default: begin
            case ($urandom_range(0, 3))
               0: begin
                  send_char(CH_DASH);
                  send_char(word_char());
               end
               1: begin
                  send_char(CH_LBRACK);
                  send_repeat(CH_EQ, $urandom_range(0, 3));
                  send_char(word_char());
               end
               2: begin
                  send_text("--[");
                  send_repeat(CH_EQ, $urandom_range(0, 3));
                  send_char(word_char());
                  send_char(CH_NL);
               end
               default: begin
                  send_text("co");
                  send_char(word_char());
               end
            endcase
         end
      endcase
      // stray beats between scans
      if ($urandom_range(0, 7) == 0)
         for (int i = $urandom_range(1, 3); i > 0; i--) send_char(noise_char());
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      directed_scans();
      directed_beats = beats_sent;

      // random scans under three stall mixes
      while (beats_sent - directed_beats < RANDOM_BEATS) begin
         if (beats_sent - directed_beats < RANDOM_BEATS / 3) begin
            send_idle_pct = 6;
            rcv_stall_pct = 62;
         end else if (beats_sent - directed_beats < 2 * RANDOM_BEATS / 3) begin
            send_idle_pct = 62;
            rcv_stall_pct = 6;
         end else begin
            send_idle_pct = 0;
            rcv_stall_pct = 0;
         end
         random_scan();
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Sent %0d beats: directed scans and random scans under three stall mixes;",
               beats_sent);
      $display("checked %0d results, %0d accepted tokens.", results, accepts);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
